/* rtl/core/stbs_pkg.sv */
package stbs_pkg;

	// default sizes of the table
	localparam int DEPTH_DEF   = 64;
	localparam int VALUE_W_DEF = 32;

	// command field and result index widths
	localparam int CMD_W   = 2;
	localparam int INDEX_W = 6;

	// command codes
	localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
	localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd2;

	// search sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PROBE,
		ST_CMP,
		ST_DONE
	} state_t;

	// outcome of the shared compare unit
	typedef struct packed {
		logic eq;
		logic lt;
	} cmp_res_t;

endpackage

/* rtl/core/stbs_ram.sv */
module stbs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

/* rtl/core/stbs_cmp.sv */
module stbs_cmp
	import stbs_pkg::*;
#(
	parameter int WIDTH = 32
) (
	input  logic [WIDTH-1:0] entry,
	input  logic [WIDTH-1:0] key,
	output cmp_res_t         res
);

	// two's complement compare of a table entry against the search key
	always_comb begin
		res.eq = (entry == key);
		res.lt = ($signed(entry) < $signed(key));
	end

endmodule

/* rtl/core/sorted_table_binary_search.sv */
// Sorted table with binary search over a table RAM with registered read.
// Clear and append: no result transaction, one per cycle while no search is in progress.
// Search: P probes, P <= clog2(DEPTH) + 1, each a RAM read in ST_PROBE and a compare in ST_CMP;
// a hit goes to ST_DONE from ST_CMP, a miss from ST_PROBE, and ST_DONE loads the result.
// s_tready stays low until the result is loaded (plus any m_tready wait on the previous one).
// Reset clears the entry count, the sequencer and the output valid; table contents are kept.
module sorted_table_binary_search
	import stbs_pkg::*;
#(
	parameter int DEPTH       = DEPTH_DEF,
	parameter int VALUE_WIDTH = VALUE_W_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [((VALUE_WIDTH+7)/8)*8-1:0]    s_tdata,  // [VALUE_WIDTH-1:0] value
	input  logic [CMD_W-1:0]                    s_tuser,  // [1:0] cmd
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [7:0]                          m_tdata,  // [5:0] index
	output logic                                m_tuser   // [0] found
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	state_t                 state_q, state_d;
	logic [CW-1:0]          count_q;
	logic [CW-1:0]          lo_q, hie_q, mid_q;
	logic [CW-1:0]          span, mid;
	logic [VALUE_WIDTH-1:0] key_q;
	logic [VALUE_WIDTH-1:0] rd_data;
	logic                   hit_q;
	logic                   m_valid_q;
	logic                   found_q;
	logic [INDEX_W-1:0]     index_q;
	logic [CW+INDEX_W-1:0]  mid_ext;
	logic                   accept;
	logic                   start;
	logic                   wr_en;
	logic                   rd_en;
	logic                   load_out;
	logic                   step_lo, step_hi, set_hit;
	cmp_res_t               cmp;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = m_valid_q;
	assign m_tuser  = found_q;
	assign m_tdata  = {{(8 - INDEX_W){1'b0}}, index_q};

	// midpoint of the half-open window [lo, hie)
	assign span    = hie_q - lo_q - CW'(1);
	assign mid     = lo_q + (span >> 1);
	assign mid_ext = {{INDEX_W{1'b0}}, mid_q};

	stbs_ram #(
		.WIDTH (VALUE_WIDTH),
		.DEPTH (DEPTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (count_q[AW-1:0]),
		.wr_data (s_tdata[VALUE_WIDTH-1:0]),
		.rd_en   (rd_en),
		.rd_addr (mid[AW-1:0]),
		.rd_data (rd_data)
	);

	stbs_cmp #(
		.WIDTH (VALUE_WIDTH)
	) u_cmp (
		.entry (rd_data),
		.key   (key_q),
		.res   (cmp)
	);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and control strobes
	always_comb begin
		state_d  = state_q;
		wr_en    = 1'b0;
		start    = 1'b0;
		rd_en    = 1'b0;
		step_lo  = 1'b0;
		step_hi  = 1'b0;
		set_hit  = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (s_tuser)
						CMD_APPEND: wr_en = (count_q < CW'(DEPTH));
						CMD_SEARCH: begin
							start   = 1'b1;
							state_d = ST_PROBE;
						end
						default: ;
					endcase
				end
			end
			ST_PROBE: begin
				if (lo_q < hie_q) begin
					rd_en   = 1'b1;
					state_d = ST_CMP;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_CMP: begin
				if (cmp.eq) begin
					set_hit = 1'b1;
					state_d = ST_DONE;
				end else begin
					step_lo = cmp.lt;
					step_hi = !cmp.lt;
					state_d = ST_PROBE;
				end
			end
			ST_DONE: begin
				if (!m_valid_q || m_tready) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept && s_tuser == CMD_CLEAR) begin
			count_q <= '0;
		end else if (wr_en) begin
			count_q <= count_q + CW'(1);
		end
	end

	// search window, key and hit
	always_ff @(posedge clk) begin
		if (start) begin
			lo_q  <= '0;
			hie_q <= count_q;
			key_q <= s_tdata[VALUE_WIDTH-1:0];
			hit_q <= 1'b0;
		end
		if (rd_en) begin
			mid_q <= mid;
		end
		if (step_lo) begin
			lo_q <= mid_q + CW'(1);
		end
		if (step_hi) begin
			hie_q <= mid_q;
		end
		if (set_hit) begin
			hit_q <= 1'b1;
		end
	end

	// output register: hold until the transaction completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (load_out) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			found_q <= hit_q;
			index_q <= hit_q ? mid_ext[INDEX_W-1:0] : '0;
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count beyond table depth");

	a_probe_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CMP) |-> (mid_q < count_q))
		else $error("probe outside filled entries");

	a_window_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PROBE) |-> (lo_q <= hie_q))
		else $error("search window inverted");

	a_search_start: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && s_tuser == CMD_SEARCH) |=> (state_q == ST_PROBE && !hit_q))
		else $error("search did not start");
`endif

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps

module testbench;
	import stbs_pkg::*;

	localparam int DATA_W = ((VALUE_W_DEF + 7) / 8) * 8;
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam int PHASE_ITEMS = 300;

	typedef struct packed {
		logic [CMD_W-1:0]              cmd;
		logic signed [VALUE_W_DEF-1:0] value;
	} lookup_req_t;

	typedef struct packed {
		logic               found;
		logic [INDEX_W-1:0] index;
	} lookup_ans_t;

	logic              clk      = 1'b0;
	logic              arst_n   = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [DATA_W-1:0] s_tdata  = '0;  // [31:0] value
	logic [CMD_W-1:0]  s_tuser  = '0;  // [1:0] cmd
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [7:0]        m_tdata;        // [5:0] index
	logic              m_tuser;        // [0] found

	sorted_table_binary_search uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// stimulus waiting for the driver and answers waiting for the block
	lookup_req_t pending_reqs[$];
	lookup_ans_t answers_due[$];

	// shadow copy of the table
	logic signed [VALUE_W_DEF-1:0] shadow_table [DEPTH_DEF];
	int shadow_count = 0;

	int  send_gap_pct   = 0;
	int  recv_stall_pct = 0;
	int  reqs_queued    = 0;
	int  reqs_taken     = 0;
	int  mismatches     = 0;
	bit  took_req       = 1'b0;

	// clock
	initial begin
		forever #2 clk = ~clk;
	end

	// overall time limit
	initial begin
		#2_000_000;
		$display("testbench NOT OK");
		$finish;
	end

	// update the shadow table and predict the answer of a search
	task automatic apply_to_shadow(input lookup_req_t rq);
		lookup_ans_t ans;
		int lo;
		int hi;
		int mid;
		ans = '0;
		case (rq.cmd)
			CMD_CLEAR: begin
				shadow_count = 0;
			end
			CMD_APPEND: begin
				if (shadow_count < DEPTH_DEF) begin
					shadow_table[shadow_count] = rq.value;
					shadow_count++;
				end
			end
			CMD_SEARCH: begin
				lo = 0;
				hi = shadow_count - 1;
				while (lo <= hi) begin
					mid = lo + (hi - lo) / 2;
					if ($signed(shadow_table[mid]) == $signed(rq.value)) begin
						ans.found = 1'b1;
						ans.index = mid[INDEX_W-1:0];
						break;
					end else if ($signed(shadow_table[mid]) < $signed(rq.value)) begin
						lo = mid + 1;
					end else begin
						hi = mid - 1;
					end
				end
				answers_due.push_back(ans);
			end
			default: ;
		endcase
	endtask

	// sample both sides: check answers, then predict from the accepted request
	always @(posedge clk) begin
		lookup_ans_t exp_ans;
		took_req = arst_n && s_tvalid && s_tready;
		if (arst_n && m_tvalid && m_tready) begin
			if (answers_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected answer: found %0b index %0d", m_tuser, m_tdata);
			end else begin
				exp_ans = answers_due.pop_front();
				if (m_tuser !== exp_ans.found || m_tdata !== {2'b00, exp_ans.index}) begin
					mismatches++;
					if (mismatches <= 10)
						$display("answer mismatch: expected found %0b index %0d, got found %0b tdata %0d",
							exp_ans.found, exp_ans.index, m_tuser, m_tdata);
				end
			end
		end
		if (took_req) begin
			reqs_taken++;
			apply_to_shadow('{cmd: s_tuser, value: s_tdata});
		end
	end

	// drive requests and result backpressure
	always @(negedge clk) begin
		lookup_req_t nxt;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
			// advance only when the current transaction is gone
			if (!s_tvalid || took_req) begin
				if (pending_reqs.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
					nxt = pending_reqs.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= nxt.value;
					s_tuser  <= nxt.cmd;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	task automatic queue_req(input logic [CMD_W-1:0] cmd, input logic [31:0] value);
		pending_reqs.push_back('{cmd: cmd, value: value});
		reqs_queued++;
	endtask

	// pick a target: stored value, neighbor, extreme or random
	task automatic queue_searches(input int vals[$], input int n);
		int pick;
		int tgt;
		repeat (n) begin
			pick = $urandom_range(9);
			if (vals.size() != 0 && pick < 5)
				tgt = vals[$urandom_range(vals.size() - 1)];
			else if (vals.size() != 0 && pick < 7)
				tgt = vals[$urandom_range(vals.size() - 1)] + ($urandom_range(1) ? 1 : -1);
			else if (pick == 7)
				tgt = $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
			else
				tgt = $urandom();
			queue_req(CMD_SEARCH, tgt);
		end
	endtask

	// clear, append a run of values (sorted or not), then search it
	task automatic queue_table_run(input int n, input bit sorted, input bit narrow);
		int vals[$];
		repeat (n) vals.push_back(narrow ? ($urandom_range(20) - 10) : int'($urandom()));
		if (sorted)
			vals.sort();
		queue_req(CMD_CLEAR, $urandom());
		foreach (vals[i])
			queue_req(CMD_APPEND, vals[i]);
		queue_searches(vals, $urandom_range(1, 8));
	endtask

	// hold the sender until every answer is back
	task automatic wait_drained();
		while (reqs_taken != reqs_queued || answers_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic queue_random_phase();
		int start;
		int r;
		int n;
		start = reqs_queued;
		while (reqs_queued - start < PHASE_ITEMS) begin
			r = $urandom_range(99);
			if (r < 75) begin
				n = $urandom_range(99);
				if (n < 85)
					n = $urandom_range(0, 12);
				else if (n < 96)
					n = $urandom_range(13, DEPTH_DEF);
				else
					n = DEPTH_DEF + $urandom_range(1, 3);
				queue_table_run(n, 1'b1, $urandom_range(3) == 0);
			end else if (r < 85) begin
				queue_table_run($urandom_range(1, 10), 1'b0, $urandom_range(1) == 0);
			end else begin
				// noise: any command, including the unused one
				repeat ($urandom_range(1, 5))
					queue_req(CMD_W'($urandom_range(3)), $urandom());
			end
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: empty table, extremes, misses, unused command, unsorted, duplicates
		queue_req(CMD_CLEAR, 32'h0);
		queue_req(CMD_SEARCH, 32'h0);
		queue_req(CMD_UNUSED, 32'hFFFF_FFFF);
		queue_req(CMD_SEARCH, 32'h5);
		queue_req(CMD_APPEND, 32'h8000_0000);
		queue_req(CMD_APPEND, -7);
		queue_req(CMD_APPEND, 32'h0);
		queue_req(CMD_APPEND, 7);
		queue_req(CMD_APPEND, 32'h7FFF_FFFF);
		queue_req(CMD_SEARCH, 32'h8000_0000);
		queue_req(CMD_SEARCH, 32'h7FFF_FFFF);
		queue_req(CMD_SEARCH, 32'h0);
		queue_req(CMD_SEARCH, -7);
		queue_req(CMD_SEARCH, 7);
		queue_req(CMD_SEARCH, 3);
		queue_req(CMD_SEARCH, 32'h8000_0001);
		queue_req(CMD_SEARCH, 32'h7FFF_FFFE);
		queue_req(CMD_APPEND, 5);
		queue_req(CMD_SEARCH, 5);
		queue_req(CMD_CLEAR, 32'hFFFF_FFFF);
		queue_req(CMD_APPEND, 4);
		queue_req(CMD_APPEND, 4);
		queue_req(CMD_APPEND, 4);
		queue_req(CMD_SEARCH, 4);
		queue_req(CMD_SEARCH, 3);

		// sender idles lightly, receiver heavily
		send_gap_pct   = 14;
		recv_stall_pct = 46;
		queue_random_phase();
		wait_drained();

		// the other way round
		send_gap_pct   = 46;
		recv_stall_pct = 14;
		queue_random_phase();
		wait_drained();

		// full rate on both sides
		send_gap_pct   = 0;
		recv_stall_pct = 0;
		queue_random_phase();
		wait_drained();

		repeat (40) @(posedge clk);
		if (mismatches == 0 && answers_due.size() == 0) begin
			$display("testbench OK");
		end else begin
			$display("testbench NOT OK");
		end
		$finish;
	end

endmodule
